// ===== rtl/integral_image_hat_contrast_test_core_macros.svh =====
// assertion helpers shared by the rtl files
`ifndef INTEGRAL_IMAGE_HAT_CONTRAST_TEST_CORE_MACROS_SVH
`define INTEGRAL_IMAGE_HAT_CONTRAST_TEST_CORE_MACROS_SVH

// checked only out of reset
`define IIC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define IIC_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/iic_pkg.sv =====
package iic_pkg;

  localparam int ENTRY_W   = 26;
  localparam int RSUM_W    = 17;
  localparam int MEAN_W    = 29;
  localparam int DIV_W     = 32;
  localparam int DVSR_W    = 18;
  localparam int BLK_W     = 4;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_DATA_W-1:0] CFG_DIM_RESET = 10'd512;
  localparam logic [CFG_DATA_W-1:0] DIM_MIN       = 10'd16;

  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  localparam logic [7:0] SIZE_MIN      = 8'd5;
  localparam logic [7:0] SIZE_RAD_SAT  = 8'd8;
  localparam logic [3:0] RADIUS_MAX    = 4'd15;
  localparam int         BORDER_MARGIN = 3;

  localparam logic [DVSR_W-1:0] THR_HI_DIV = 18'd100;
  localparam logic [DVSR_W-1:0] THR_LO_DIV = 18'd10;
  localparam logic signed [MEAN_W-1:0] THR_HI_MIN = 29'sd20;
  localparam logic signed [MEAN_W-1:0] THR_LO_MAX = 29'sd10;

  localparam logic [BLK_W-1:0] BLK_CENTRE    = 4'd4;
  localparam logic [BLK_W-1:0] BLK_LAST_MEAN = 4'd8;
  localparam logic [BLK_W-1:0] BLK_THR_HI    = 4'd9;
  localparam logic [BLK_W-1:0] BLK_THR_LO    = 4'd10;
  localparam int               NUM_BLK       = 9;

  localparam logic [1:0] CRN_TL = 2'd0;
  localparam logic [1:0] CRN_BR = 2'd1;
  localparam logic [1:0] CRN_TR = 2'd2;
  localparam logic [1:0] CRN_BL = 2'd3;

  localparam logic [1:0] BAND_LO  = 2'd0;
  localparam logic [1:0] BAND_MID = 2'd1;
  localparam logic [1:0] BAND_HI  = 2'd2;

  typedef struct packed {
    logic       req_type;
    logic [7:0] pixel;
    logic [8:0] key_x;
    logic [8:0] key_y;
    logic [7:0] key_size;
  } req_t;

  typedef struct packed {
    logic       response;
    logic       border_reject;
    logic [7:0] centre_mean;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_WR,
    ST_Q_CHK,
    ST_Q_RD,
    ST_Q_ACC,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic             accept;
    logic             ld_wr;
    logic             q_rd;
    logic             div_start;
    logic             div_store;
    logic             emit;
    logic             emit_reject;
    logic [BLK_W-1:0] blk;
    logic [1:0]       crn;
  } cmd_t;

  typedef struct packed {
    logic border;
    logic div_done;
  } status_t;

  // row band of a block: blocks run in raster order over a 3x3 grid
  function automatic logic [1:0] blk_row_band(input logic [BLK_W-1:0] blk);
    logic [1:0] b;
    case (blk)
      4'd0, 4'd1, 4'd2: b = BAND_LO;
      4'd3, 4'd4, 4'd5: b = BAND_MID;
      default:          b = BAND_HI;
    endcase
    return b;
  endfunction

  function automatic logic [1:0] blk_col_band(input logic [BLK_W-1:0] blk);
    logic [1:0] b;
    case (blk)
      4'd0, 4'd3, 4'd6: b = BAND_LO;
      4'd1, 4'd4, 4'd7: b = BAND_MID;
      default:          b = BAND_HI;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/integral_image_hat_contrast_test_core.sv =====
// integral image centre/surround contrast test
//
// one command channel: start_i with req_i is taken when busy_o is low.
// req_type 0 loads the next pixel in raster order into the integral store,
// req_type 1 queries a keypoint. results leave on res_o, marked by a single
// cycle done_o beat; there is no back pressure, the receiver must take it.
// a load holds busy while it writes the store and gives no result.
// a query rejected at the border gives its beat from the border check state via the result register.
// a full query does four store reads and then a divide per block; nine block
// means plus two threshold divides all share one bit-per-cycle divider.
// the next command can be accepted in the same cycle the result beat shows.
// config (cfg_we_i, cfg_idx_i: 0 width, 1 height) must be written while idle; the block does not enforce it.
// reset clears the load position, the running row sum and the state machine,
// and sets both dimensions to 512; the store itself is not cleared, so
// queries may only touch pixels loaded since reset.
module integral_image_hat_contrast_test_core #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  iic_pkg::req_t                  req_i,
  output logic                           busy_o,
  output logic                           done_o,
  output iic_pkg::res_t                  res_o,
  input  logic                           cfg_we_i,
  input  logic                           cfg_idx_i,
  input  logic [iic_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  // controller and datapath talk only through these two groups
  iic_pkg::cmd_t    cmd;
  iic_pkg::status_t status;

  iic_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .query_i  (req_i.req_type),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // datapath holds the store, the geometry, the divider and the result register
  iic_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .done_o     (done_o),
    .res_o      (res_o)
  );

endmodule

// ===== rtl/iic_ram.sv =====
module iic_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 262144
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/iic_div.sv =====
module iic_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [iic_pkg::DIV_W-1:0]     dividend_i,
  input  logic        [iic_pkg::DVSR_W-1:0]    divisor_i,
  output logic                                 done_o,
  output logic signed [iic_pkg::DIV_W-1:0]     quotient_o
);

  localparam int DW  = iic_pkg::DIV_W;
  localparam int VW  = iic_pkg::DVSR_W;
  localparam int CNW = $clog2(DW + 1);

  logic [CNW-1:0] cnt_q, cnt_d;
  logic           run_q, run_d;
  logic           done_q, done_d;
  logic [DW-1:0]  mag_q, mag_d;
  logic [VW:0]    rem_q, rem_d;
  logic [VW-1:0]  dvsr_q, dvsr_d;
  logic           neg_q, neg_d;
  logic [VW:0]    rem_sh;
  logic           fits;

  // restoring division of the magnitude, one quotient bit per cycle
  always_comb begin
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    mag_d  = mag_q;
    rem_d  = rem_q;
    dvsr_d = dvsr_q;
    neg_d  = neg_q;
    rem_sh = {rem_q[VW-1:0], mag_q[DW-1]};
    fits   = rem_sh >= {1'b0, dvsr_q};
    if (start_i) begin
      run_d  = 1'b1;
      cnt_d  = '0;
      neg_d  = dividend_i[DW-1];
      mag_d  = dividend_i[DW-1] ? DW'(-dividend_i) : DW'(dividend_i);
      rem_d  = '0;
      dvsr_d = divisor_i;
    end else if (run_q) begin
      mag_d = {mag_q[DW-2:0], fits};
      rem_d = fits ? (rem_sh - {1'b0, dvsr_q}) : rem_sh;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNW'(DW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    rem_q  <= rem_d;
    dvsr_q <= dvsr_d;
    neg_q  <= neg_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? -$signed(mag_q) : $signed(mag_q);

endmodule

// ===== rtl/iic_ctrl.sv =====
`include "integral_image_hat_contrast_test_core_macros.svh"

module iic_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             query_i,
  input  iic_pkg::status_t status_i,
  output iic_pkg::cmd_t    cmd_o,
  output logic             busy_o
);

  iic_pkg::state_e                state_q, state_d;
  logic [iic_pkg::BLK_W-1:0]      blk_q, blk_d;
  logic [1:0]                     crn_q, crn_d;
  iic_pkg::cmd_t                  cmd;

  always_comb begin
    state_d = state_q;
    blk_d   = blk_q;
    crn_d   = crn_q;
    cmd     = '0;
    case (state_q)
      iic_pkg::ST_IDLE: begin
        if (start_i) begin
          cmd.accept = 1'b1;
          state_d    = query_i ? iic_pkg::ST_Q_CHK : iic_pkg::ST_LD_WR;
        end
      end
      iic_pkg::ST_LD_WR: begin
        cmd.ld_wr = 1'b1;
        state_d   = iic_pkg::ST_IDLE;
      end
      iic_pkg::ST_Q_CHK: begin
        if (status_i.border) begin
          cmd.emit_reject = 1'b1;
          state_d         = iic_pkg::ST_IDLE;
        end else begin
          blk_d   = '0;
          crn_d   = iic_pkg::CRN_TL;
          state_d = iic_pkg::ST_Q_RD;
        end
      end
      iic_pkg::ST_Q_RD: begin
        cmd.q_rd = 1'b1;
        crn_d    = crn_q + 2'd1;
        if (crn_q == iic_pkg::CRN_BL) begin
          state_d = iic_pkg::ST_Q_ACC;
        end
      end
      iic_pkg::ST_Q_ACC: begin
        state_d = iic_pkg::ST_DIV_GO;
      end
      iic_pkg::ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_d       = iic_pkg::ST_DIV_WAIT;
      end
      iic_pkg::ST_DIV_WAIT: begin
        if (status_i.div_done) begin
          cmd.div_store = 1'b1;
          if (blk_q == iic_pkg::BLK_THR_LO) begin
            state_d = iic_pkg::ST_EMIT;
          end else begin
            blk_d   = blk_q + 1'b1;
            state_d = (blk_q < iic_pkg::BLK_LAST_MEAN) ? iic_pkg::ST_Q_RD
                                                       : iic_pkg::ST_DIV_GO;
          end
        end
      end
      iic_pkg::ST_EMIT: begin
        cmd.emit = 1'b1;
        state_d  = iic_pkg::ST_IDLE;
      end
      default: begin
        state_d = iic_pkg::ST_IDLE;
      end
    endcase
    cmd.blk = blk_q;
    cmd.crn = crn_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iic_pkg::ST_IDLE;
      blk_q   <= '0;
      crn_q   <= '0;
    end else begin
      state_q <= state_d;
      blk_q   <= blk_d;
      crn_q   <= crn_d;
    end
  end

  assign cmd_o  = cmd;
  assign busy_o = state_q != iic_pkg::ST_IDLE;

  `IIC_ASSERT_ANY(a_crn_only_in_read, (crn_q != 2'd0) |-> (state_q == iic_pkg::ST_Q_RD), "corner count outside read phase")
  `IIC_ASSERT_RST(a_query_goes_check, (cmd.accept && query_i) |=> (state_q == iic_pkg::ST_Q_CHK), "query did not reach border check")
  `IIC_ASSERT_RST(a_div_done_waited, status_i.div_done |-> (state_q == iic_pkg::ST_DIV_WAIT), "divider finished while not awaited")

endmodule

// ===== rtl/iic_dp.sv =====
`include "integral_image_hat_contrast_test_core_macros.svh"

module iic_dp #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  iic_pkg::req_t                       req_i,
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [iic_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  iic_pkg::cmd_t                       cmd_i,
  output iic_pkg::status_t                    status_o,
  output logic                                done_o,
  output iic_pkg::res_t                       res_o
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int XW    = $clog2(MAX_WIDTH + 1);
  localparam int YW    = $clog2(MAX_HEIGHT + 1);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int DIM_W = (XW > YW) ? XW : YW;
  localparam int BW    = ((DIM_W > 10) ? DIM_W : 10) + 1;
  localparam int EW    = iic_pkg::ENTRY_W;
  localparam int MW    = iic_pkg::MEAN_W;
  localparam int DW    = iic_pkg::DIV_W;
  localparam int VW    = iic_pkg::DVSR_W;

  // configuration
  logic [iic_pkg::CFG_DATA_W-1:0] width_q, height_q;
  logic [XW-1:0] img_w;
  logic [YW-1:0] img_h;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= iic_pkg::CFG_DIM_RESET;
      height_q <= iic_pkg::CFG_DIM_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == iic_pkg::CFG_IDX_WIDTH) begin
        width_q <= cfg_data_i;
      end
      if (cfg_idx_i == iic_pkg::CFG_IDX_HEIGHT) begin
        height_q <= cfg_data_i;
      end
    end
  end

  always_comb begin
    if (width_q < iic_pkg::DIM_MIN) begin
      img_w = XW'(iic_pkg::DIM_MIN);
    end else if (32'(width_q) > MAX_WIDTH) begin
      img_w = XW'(MAX_WIDTH);
    end else begin
      img_w = XW'(width_q);
    end
    if (height_q < iic_pkg::DIM_MIN) begin
      img_h = YW'(iic_pkg::DIM_MIN);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      img_h = YW'(MAX_HEIGHT);
    end else begin
      img_h = YW'(height_q);
    end
  end

  // load path
  logic [CW-1:0]               col_q;
  logic [RW-1:0]               row_q;
  logic [iic_pkg::RSUM_W-1:0]  rsum_q;
  logic                        col_wrap, row_wrap;
  logic [AW-1:0]               ld_raddr, ld_waddr;
  logic [EW-1:0]               ld_wdata, rd_data;

  assign col_wrap = (XW'(col_q) + XW'(1)) >= img_w;
  assign row_wrap = (YW'(row_q) + YW'(1)) >= img_h;
  assign ld_waddr = AW'(row_q) * AW'(MAX_WIDTH) + AW'(col_q);
  assign ld_raddr = AW'(row_q - RW'(1)) * AW'(MAX_WIDTH) + AW'(col_q);
  assign ld_wdata = ((row_q != '0) ? rd_data : '0) + EW'(rsum_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      rsum_q <= '0;
    end else if (cmd_i.accept && !req_i.req_type) begin
      rsum_q <= rsum_q + iic_pkg::RSUM_W'(req_i.pixel);
    end else if (cmd_i.ld_wr) begin
      if (col_wrap) begin
        col_q  <= '0;
        rsum_q <= '0;
        row_q  <= row_wrap ? '0 : row_q + RW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // query geometry
  iic_pkg::req_t req_q;
  logic [7:0]    s_eff;
  logic [3:0]    rad;
  logic [8:0]    ext;
  logic          border;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q <= req_i;
    end
  end

  assign s_eff = (req_q.key_size < iic_pkg::SIZE_MIN) ? iic_pkg::SIZE_MIN : req_q.key_size;
  assign rad   = (s_eff >= iic_pkg::SIZE_RAD_SAT) ? iic_pkg::RADIUS_MAX : 4'(s_eff << 1);
  assign ext   = 9'(s_eff) + 9'(rad);

  assign border =
      (BW'(req_q.key_x) + BW'(ext) + BW'(iic_pkg::BORDER_MARGIN) >= BW'(img_w)) ||
      (BW'(req_q.key_y) + BW'(ext) + BW'(iic_pkg::BORDER_MARGIN) >= BW'(img_h)) ||
      (BW'(req_q.key_x) <= BW'(ext) + BW'(iic_pkg::BORDER_MARGIN)) ||
      (BW'(req_q.key_y) <= BW'(ext) + BW'(iic_pkg::BORDER_MARGIN));

  logic [9:0] cx_lo, cx_hi, cy_lo, cy_hi;
  logic [8:0] csz, rsz;
  logic [1:0] rb, cb;
  logic [9:0] le, ri, to, bo;
  logic [9:0] crow, ccol;
  logic [AW-1:0] q_raddr;

  assign le = 10'(req_q.key_x) - 10'(s_eff);
  assign ri = 10'(req_q.key_x) + 10'(s_eff);
  assign to = 10'(req_q.key_y) - 10'(s_eff);
  assign bo = 10'(req_q.key_y) + 10'(s_eff);
  assign rb = iic_pkg::blk_row_band(cmd_i.blk);
  assign cb = iic_pkg::blk_col_band(cmd_i.blk);

  always_comb begin
    case (cb)
      iic_pkg::BAND_LO: begin
        cx_lo = le - 10'(rad);
        cx_hi = le;
        csz   = 9'(rad) + 9'd1;
      end
      iic_pkg::BAND_MID: begin
        cx_lo = le;
        cx_hi = ri;
        csz   = {s_eff, 1'b1};
      end
      default: begin
        cx_lo = ri;
        cx_hi = ri + 10'(rad);
        csz   = 9'(rad) + 9'd1;
      end
    endcase
    case (rb)
      iic_pkg::BAND_LO: begin
        cy_lo = to - 10'(rad);
        cy_hi = to;
        rsz   = 9'(rad) + 9'd1;
      end
      iic_pkg::BAND_MID: begin
        cy_lo = to;
        cy_hi = bo;
        rsz   = {s_eff, 1'b1};
      end
      default: begin
        cy_lo = bo;
        cy_hi = bo + 10'(rad);
        rsz   = 9'(rad) + 9'd1;
      end
    endcase
    case (cmd_i.crn)
      iic_pkg::CRN_TL: begin
        crow = cy_lo;
        ccol = cx_lo;
      end
      iic_pkg::CRN_BR: begin
        crow = cy_hi;
        ccol = cx_hi;
      end
      iic_pkg::CRN_TR: begin
        crow = cy_lo;
        ccol = cx_hi;
      end
      default: begin
        crow = cy_hi;
        ccol = cx_lo;
      end
    endcase
  end

  assign q_raddr = AW'(crow) * AW'(MAX_WIDTH) + AW'(ccol);

  // integral store
  logic          ram_re;
  logic [AW-1:0] ram_raddr;

  assign ram_re    = (cmd_i.accept && !req_i.req_type && row_q != '0) || cmd_i.q_rd;
  assign ram_raddr = cmd_i.q_rd ? q_raddr : ld_raddr;

  iic_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ld_wr),
    .waddr_i (ld_waddr),
    .wdata_i (ld_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_data)
  );

  // four-corner accumulation on the registered read data of the store
  logic                 acc_pend_q;
  logic [1:0]           acc_crn_q;
  logic signed [MW-1:0] acc_q, rd_ext, acc_base;

  assign rd_ext   = $signed(MW'(rd_data));
  assign acc_base = (acc_crn_q == iic_pkg::CRN_TL) ? '0 : acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_pend_q <= 1'b0;
    end else begin
      acc_pend_q <= cmd_i.q_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_crn_q <= cmd_i.crn;
    if (acc_pend_q) begin
      if (acc_crn_q == iic_pkg::CRN_TL || acc_crn_q == iic_pkg::CRN_BR) begin
        acc_q <= acc_base + rd_ext;
      end else begin
        acc_q <= acc_base - rd_ext;
      end
    end
  end

  // shared divider: nine block means, then the two thresholds
  logic signed [MW-1:0] mean_q [iic_pkg::NUM_BLK];
  logic signed [MW-1:0] thr_hi_q, thr_lo_q, centre;
  logic signed [DW-1:0] c_ext, div_a, quot;
  logic [VW-1:0]        div_b;
  logic                 div_done;
  logic signed [MW-1:0] quot_n;

  assign centre = mean_q[iic_pkg::BLK_CENTRE];
  assign c_ext  = {{(DW - MW){centre[MW-1]}}, centre};
  assign quot_n = quot[MW-1:0];

  always_comb begin
    if (cmd_i.blk == iic_pkg::BLK_THR_HI) begin
      div_a = (c_ext <<< 4) - c_ext;
      div_b = iic_pkg::THR_HI_DIV;
    end else if (cmd_i.blk == iic_pkg::BLK_THR_LO) begin
      div_a = c_ext;
      div_b = iic_pkg::THR_LO_DIV;
    end else begin
      div_a = {{(DW - MW){acc_q[MW-1]}}, acc_q};
      div_b = VW'(csz * rsz);
    end
  end

  iic_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_store) begin
      if (cmd_i.blk == iic_pkg::BLK_THR_HI) begin
        thr_hi_q <= (quot_n < iic_pkg::THR_HI_MIN) ? iic_pkg::THR_HI_MIN : quot_n;
      end else if (cmd_i.blk == iic_pkg::BLK_THR_LO) begin
        thr_lo_q <= (quot_n > iic_pkg::THR_LO_MAX) ? iic_pkg::THR_LO_MAX : quot_n;
      end else begin
        mean_q[cmd_i.blk] <= quot_n;
      end
    end
  end

  // contrast decision against the eight surrounds
  logic [7:0]           hi_ok, lo_ok;
  logic signed [MW:0]   c_w, s_w, th_w, tl_w;
  logic [7:0]           c_sat;

  always_comb begin
    c_w  = {centre[MW-1], centre};
    th_w = {thr_hi_q[MW-1], thr_hi_q};
    tl_w = {thr_lo_q[MW-1], thr_lo_q};
    s_w  = '0;
    for (int k = 0; k < 8; k++) begin
      s_w      = (k < 4) ? {mean_q[k][MW-1], mean_q[k]}
                         : {mean_q[k + 1][MW-1], mean_q[k + 1]};
      hi_ok[k] = c_w > (s_w + th_w);
      lo_ok[k] = c_w > (s_w + tl_w);
    end
    if (centre < 0) begin
      c_sat = 8'd0;
    end else if (centre > 255) begin
      c_sat = 8'd255;
    end else begin
      c_sat = centre[7:0];
    end
  end

  iic_pkg::res_t res_q;
  logic          done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.emit || cmd_i.emit_reject;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_reject) begin
      res_q.response      <= 1'b0;
      res_q.border_reject <= 1'b1;
      res_q.centre_mean   <= 8'd0;
    end else if (cmd_i.emit) begin
      res_q.response      <= (&lo_ok) && (|hi_ok);
      res_q.border_reject <= 1'b0;
      res_q.centre_mean   <= c_sat;
    end
  end

  assign status_o.border   = border;
  assign status_o.div_done = div_done;
  assign done_o            = done_q;
  assign res_o             = res_q;

  `IIC_ASSERT_RST(a_reject_is_clean, (done_q && res_q.border_reject) |-> (!res_q.response && res_q.centre_mean == 8'd0), "border reject carries data")
  `IIC_ASSERT_RST(a_no_read_on_write, cmd_i.ld_wr |-> !ram_re, "store read and load write collide")

endmodule

// ===== tb/sv/integral_image_hat_contrast_test_core_test.sv =====
`timescale 1ns / 100ps

module integral_image_hat_contrast_test_core_test;
  import iic_pkg::*;

  localparam int MAXW = 512;
  localparam int MAXH = 512;
  localparam int DEPTH = MAXW * MAXH;
  localparam int IDLE_LIMIT = 20000;
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start_i;
  req_t req_i;
  logic busy_o;
  logic done_o;
  res_t res_o;
  logic cfg_we_i;
  logic cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  integral_image_hat_contrast_test_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .req_i(req_i),
    .busy_o(busy_o), .done_o(done_o), .res_o(res_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // shadow of the block: integral store, which entries were loaded, load position
  bit [ENTRY_W-1:0] integral_sh [DEPTH];
  bit loaded_sh [DEPTH];
  bit [RSUM_W-1:0] row_sum_sh;
  int unsigned col_sh, row_sh;
  bit [CFG_DATA_W-1:0] width_reg, height_reg;

  res_t pending_results[$];
  int errors = 0;
  int burst_left = 0;

  function automatic int unsigned dim_in_use(bit [CFG_DATA_W-1:0] v, int unsigned hi);
    if (v < 16) return 16;
    if (v > hi) return hi;
    return v;
  endfunction

  // one corner of the integral image; flags a read of a never-loaded entry
  function automatic longint corner(longint row, longint col, inout bit clean);
    if (row < 0 || col < 0 || row >= MAXH || col >= MAXW) return 0;
    if (!loaded_sh[row * MAXW + col]) clean = 1'b0;
    return longint'(integral_sh[row * MAXW + col]);
  endfunction

  function automatic longint box_mean(longint l, longint r, longint t, longint b,
                                      inout bit clean);
    longint v, n;
    v = corner(t, l, clean) + corner(b, r, clean) - corner(t, r, clean)
        - corner(b, l, clean);
    n = (r - l + 1) * (b - t + 1);
    if (n <= 0) return 0;
    return v / n;
  endfunction

  // expected answer of a keypoint query; clean is low when it would touch
  // entries never loaded since reset
  function automatic void contrast_answer(input req_t q, output res_t a, output bit clean);
    longint x, y, s, rad, ext, le, ri, tp, bt, c, thr, thr_lo, w, h;
    longint sur[8];
    int big, big_lo;
    clean = 1'b1;
    a = '0;
    w = dim_in_use(width_reg, MAXW);
    h = dim_in_use(height_reg, MAXH);
    x = q.key_x; y = q.key_y; s = q.key_size;
    if (s < 5) s = 5;
    rad = 2 * s;
    if (rad > 15) rad = 15;
    if (rad < 7) rad = 7;
    ext = rad + s;
    if (x + ext >= w - 3 || y + ext >= h - 3 || x - ext <= 3 || y - ext <= 3) begin
      a.border_reject = 1'b1;
      return;
    end
    le = x - s; ri = x + s; tp = y - s; bt = y + s;
    sur[0] = box_mean(le - rad, le, tp - rad, tp, clean);
    sur[1] = box_mean(le, ri, tp - rad, tp, clean);
    sur[2] = box_mean(ri, ri + rad, tp - rad, tp, clean);
    sur[3] = box_mean(le - rad, le, tp, bt, clean);
    c      = box_mean(le, ri, tp, bt, clean);
    sur[4] = box_mean(ri, ri + rad, tp, bt, clean);
    sur[5] = box_mean(le - rad, le, bt, bt + rad, clean);
    sur[6] = box_mean(le, ri, bt, bt + rad, clean);
    sur[7] = box_mean(ri, ri + rad, bt, bt + rad, clean);
    thr = (15 * c) / 100;
    if (thr < 20) thr = 20;
    thr_lo = c / 10;
    if (thr_lo > 10) thr_lo = 10;
    big = 0; big_lo = 0;
    for (int k = 0; k < 8; k++) begin
      if (c > sur[k] + thr) big++;
      if (c > sur[k] + thr_lo) big_lo++;
    end
    a.response = (big_lo == 8 && big >= 1);
    a.centre_mean = (c < 0) ? 8'd0 : (c > 255) ? 8'd255 : c[7:0];
  endfunction

  // raster load into the shadow store
  function automatic void load_pixel(bit [7:0] pix);
    bit [ENTRY_W-1:0] above;
    int unsigned w, h;
    w = dim_in_use(width_reg, MAXW);
    h = dim_in_use(height_reg, MAXH);
    row_sum_sh = row_sum_sh + pix;
    above = (row_sh > 0) ? integral_sh[(row_sh - 1) * MAXW + col_sh] : '0;
    integral_sh[row_sh * MAXW + col_sh] = above + row_sum_sh;
    loaded_sh[row_sh * MAXW + col_sh] = 1'b1;
    col_sh++;
    if (col_sh >= w) begin
      col_sh = 0;
      row_sum_sh = '0;
      row_sh++;
      if (row_sh >= h) row_sh = 0;
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // sends one beat: bursts of random length with random gaps between them
  task automatic send_beat(req_t item);
    res_t a;
    bit clean;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        start_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    start_i <= 1'b1;
    req_i <= item;
    forever begin
      @(negedge clk_i);
      if (!busy_o) break;
    end
    @(posedge clk_i);
    // accepted at this edge
    if (item.req_type == REQ_LOAD) load_pixel(item.pixel);
    else begin
      contrast_answer(item, a, clean);
      pending_results.push_back(a);
    end
  endtask

  task automatic load_beat(bit [7:0] pix);
    req_t item;
    item = $urandom;
    item.req_type = REQ_LOAD;
    item.pixel = pix;
    send_beat(item);
  endtask

  // query only if it stays on loaded entries
  task automatic query_beat(int unsigned x, int unsigned y, int unsigned sz);
    req_t item;
    res_t a;
    bit clean;
    item = $urandom;
    item.req_type = REQ_QUERY;
    item.key_x = x; item.key_y = y; item.key_size = sz;
    contrast_answer(item, a, clean);
    if (clean) send_beat(item);
  endtask

  // waits for every answer and for a load still in the block
  task automatic settle;
    start_i <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, bit [CFG_DATA_W-1:0] val);
    settle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_IDX_WIDTH) width_reg = val;
    else height_reg = val;
  endtask

  // nothing loaded yet: every query at the reset size must be a border reject
  task automatic test_reset_border;
    query_beat(0, 0, 0);
    query_beat(511, 511, 255);
    query_beat(0, 300, 128);
    query_beat(300, 511, 5);
    query_beat(508, 20, 1);
    query_beat(18, 18, 4);
    query_beat(255, 3, 255);
    query_beat(511, 0, 0);
    settle();
  endtask

  // 40 wide, 38 rows of a bright centre hat over noise; queries near the hat and at random
  task automatic test_contrast_hat;
    int unsigned lvl;
    write_reg(CFG_IDX_WIDTH, 10'd40);
    write_reg(CFG_IDX_HEIGHT, 10'd40);
    lvl = $urandom_range(120, 255);
    for (int r = 0; r < 38; r++) begin
      for (int c = 0; c < 40; c++) begin
        if (r >= 15 && r <= 25 && c >= 15 && c <= 25)
          load_beat(lvl - $urandom_range(0, 40));
        else if ($urandom_range(0, 19) == 0)
          load_beat($urandom_range(0, 255));
        else
          load_beat($urandom_range(0, 60));
      end
    end
    // directed: exact hat centre, small sizes, both border sides
    query_beat(20, 20, 5);
    query_beat(20, 20, 0);
    query_beat(19, 19, 3);
    query_beat(21, 21, 5);
    query_beat(18, 20, 5);
    query_beat(22, 20, 5);
    query_beat(20, 20, 6);
    for (int i = 0; i < 160; i++) begin
      if ($urandom_range(0, 4) != 0)
        query_beat($urandom_range(18, 22), $urandom_range(18, 22), $urandom_range(0, 7));
      else
        query_beat($urandom_range(0, 511), $urandom_range(0, 511), $urandom_range(0, 255));
    end
    settle();
  endtask

  // smallest image: registers at 0 and 15 both clamp to 16; raster wrap of rows
  task automatic test_small_wrap;
    write_reg(CFG_IDX_WIDTH, 10'd0);
    write_reg(CFG_IDX_HEIGHT, 10'd15);
    // fill the row at the load position first, then one whole 16x16 image
    for (int i = 0; i < 16 + 256; i++)
      load_beat((i % 37 == 0) ? 8'd255 : (i % 41 == 0) ? 8'd0 : 8'($urandom));
    for (int i = 0; i < 30; i++)
      query_beat($urandom_range(0, 511), $urandom_range(0, 511), $urandom);
    settle();
  endtask

  // largest registers clamp to the store size; then shrink the width mid-row
  task automatic test_max_and_shrink;
    write_reg(CFG_IDX_WIDTH, 10'd1023);
    write_reg(CFG_IDX_HEIGHT, 10'd1023);
    for (int i = 0; i < 100; i++) load_beat($urandom);
    query_beat(511, 511, 255);
    query_beat(100, 100, 0);
    write_reg(CFG_IDX_WIDTH, 10'd64);
    for (int i = 0; i < 69; i++) load_beat($urandom);
    for (int i = 0; i < 20; i++)
      query_beat($urandom_range(0, 511), $urandom_range(0, 511), $urandom);
    settle();
  endtask

  // answer checker: done_o is a single cycle beat with no back pressure
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("unexpected result beat at %0t", $realtime);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (res_o.response !== want.response)
          report_mismatch("response", res_o.response, want.response);
        if (res_o.border_reject !== want.border_reject)
          report_mismatch("border_reject", res_o.border_reject, want.border_reject);
        if (res_o.centre_mean !== want.centre_mean)
          report_mismatch("centre_mean", res_o.centre_mean, want.centre_mean);
      end
    end
  end

  // watchdog on cycles with no accepted beat and no result beat
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || !rst_ni) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni <= 1'b0;
    start_i <= 1'b0;
    req_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= 1'b0;
    cfg_data_i <= '0;
    width_reg = CFG_DIM_RESET;
    height_reg = CFG_DIM_RESET;
    row_sum_sh = '0;
    col_sh = 0;
    row_sh = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_border();
    test_contrast_hat();
    test_small_wrap();
    test_max_and_shrink();

    settle();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
